[hw/rtl/plin_pkg.sv]
`timescale 1ns / 1ps

package plin_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [5:0]         entry_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_x;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_y;
        logic               in_range;
    } t_out_item;

    // Query token walking down the row of breakpoint cells
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic signed [31:0] q;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
    } t_token;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_top_state;

    typedef enum logic [4:0] {
        IS_IDLE = 5'b00001,
        IS_MUL  = 5'b00010,
        IS_DIV  = 5'b00100,
        IS_FIN  = 5'b01000,
        IS_DONE = 5'b10000
    } t_interp_state;

endpackage

[hw/rtl/plin_cell.sv]
`timescale 1ns / 1ps

module plin_cell
    import plin_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic signed [31:0] i_wr_x,
    input  logic signed [31:0] i_wr_y,
    input  logic               i_chk_en,
    input  t_token             i_tok,
    output t_token             o_tok
);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    t_token             r_tok;
    t_token             n_tok;
    logic               w_in_seg;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end
    end

    // segment is (previous entry carried in the token, this entry)
    assign w_in_seg = i_chk_en && (i_tok.q >= i_tok.x0) && (i_tok.q <= r_x);

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit) begin
            if (w_in_seg) begin
                n_tok.hit = 1'b1;
                n_tok.x1  = r_x;
                n_tok.y1  = r_y;
            end else begin
                n_tok.x0 = r_x;
                n_tok.y0 = r_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

[hw/rtl/plin_interp.sv]
`timescale 1ns / 1ps

module plin_interp
    import plin_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_token    i_tok,
    input  logic      i_ack,
    output logic      o_done,
    output t_out_item o_res
);

    t_interp_state       r_state;
    t_interp_state       n_state;
    logic                r_hit;
    logic                r_zero;
    logic                r_neg;
    logic signed [31:0]  r_y0;
    logic [31:0]         r_dq;
    logic [31:0]         r_dx;
    logic [31:0]         r_mag;
    logic [31:0]         r_rem;
    logic [31:0]         r_num;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_out_item           r_res;

    logic [32:0] w_dx;
    logic [32:0] w_dq;
    logic [32:0] w_dy;
    logic [63:0] w_prod;
    logic [32:0] w_shift;
    logic        w_take;

    assign w_dx = {i_tok.x1[31], i_tok.x1} - {i_tok.x0[31], i_tok.x0};
    assign w_dq = {i_tok.q[31], i_tok.q} - {i_tok.x0[31], i_tok.x0};
    assign w_dy = {i_tok.y1[31], i_tok.y1} - {i_tok.y0[31], i_tok.y0};

    assign w_prod = r_dq * r_mag;

    // restoring division; for a hit in a segment of nonzero width the remainder stays below the divisor
    assign w_shift = {r_rem, r_num[31]};
    assign w_take  = (w_shift >= {1'b0, r_dx});

    always_comb begin
        n_state = r_state;
        case (r_state)
            IS_IDLE: if (i_tok.valid) n_state = IS_MUL;
            IS_MUL:  n_state = IS_DIV;
            IS_DIV:  if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = IS_FIN;
            IS_FIN:  n_state = IS_DONE;
            IS_DONE: if (i_ack) n_state = IS_IDLE;
            default: n_state = IS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            IS_IDLE: begin
                r_hit  <= i_tok.hit;
                r_zero <= (i_tok.x1 == i_tok.x0);
                r_neg  <= w_dy[32];
                r_y0   <= i_tok.y0;
                r_dq   <= w_dq[31:0];
                r_dx   <= w_dx[31:0];
                r_mag  <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
            end
            IS_MUL: begin
                r_rem <= w_prod[63:32];
                r_num <= w_prod[31:0];
                r_cnt <= '0;
            end
            IS_DIV: begin
                r_rem <= w_take ? 32'(w_shift - {1'b0, r_dx}) : w_shift[31:0];
                r_num <= {r_num[30:0], w_take};
                r_cnt <= r_cnt + 1'b1;
            end
            IS_FIN: begin
                r_res.in_range <= r_hit;
                if (!r_hit) begin
                    r_res.result_y <= '0;
                end else if (r_zero) begin
                    r_res.result_y <= r_y0;
                end else if (r_neg) begin
                    r_res.result_y <= r_y0 - $signed(r_num);
                end else begin
                    r_res.result_y <= r_y0 + $signed(r_num);
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == IS_DONE);
    assign o_res  = r_res;

endmodule

[hw/rtl/piecewise_linear_lookup.sv]
`timescale 1ns / 1ps

// Piecewise linear lookup over a table of signed Q16.16 breakpoints.
// Input channel (i_in_valid / o_in_stall / i_in_data): mode 0 writes one
// (x, y) pair at entry_index, mode 1 queries at query_x. Output channel
// (o_out_valid / i_out_stall / o_out_data) returns one result per query and
// nothing for a load. i_cfg_wr_en / i_cfg_wr_data set points_in_use; write
// it only while no query is in flight.
// Loads are taken back to back while no query is in flight. A query walks
// a row of TABLE_DEPTH breakpoint cells, one cell a cycle, then a 32x32
// multiply and a 32-step restoring divide. One query is in flight at a
// time; o_in_stall stays high meanwhile and falls at the same edge at which
// the result enters the output register.
// The output register holds a finished result while i_out_stall is high;
// a next finished result then waits inside, with o_in_stall still high,
// until the register drains.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets
// points_in_use to 2; table contents are undefined until loaded.
module piecewise_linear_lookup
    import plin_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data
);

    t_top_state r_state;
    t_top_state n_state;
    logic [6:0] r_points;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       w_accept;
    logic       w_done;
    logic       w_ack;
    t_out_item  w_res;
    t_token     w_inj;
    t_token     w_tok [TABLE_DEPTH+1];

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_inj       = '0;
        w_inj.valid = w_accept && (i_in_data.mode == MODE_QUERY);
        w_inj.q     = i_in_data.query_x;
    end

    assign w_tok[0] = w_inj;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        logic w_wr;
        logic w_chk;

        assign w_wr  = w_accept && (i_in_data.mode == MODE_LOAD)
                     && (int'(i_in_data.entry_index) == k);
        assign w_chk = (k != 0) && (k < int'(r_points));

        plin_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (w_wr),
            .i_wr_x   (i_in_data.point_x),
            .i_wr_y   (i_in_data.point_y),
            .i_chk_en (w_chk),
            .i_tok    (w_tok[k]),
            .o_tok    (w_tok[k+1])
        );
    end

    plin_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok[TABLE_DEPTH]),
        .i_ack   (w_ack),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    assign w_ack = w_done && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_inj.valid) n_state = ST_BUSY;
            ST_BUSY: if (w_ack) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_points    <= 7'd2;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_points <= i_cfg_wr_data;
            end
            if (w_ack) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[tb/sv/piecewise_linear_lookup_test.sv]
`timescale 1ns / 1ps

module piecewise_linear_lookup_test;
    import plin_pkg::*;

    localparam int ITEM_TARGET = 400;
    localparam int QUIET_TAIL  = TABLE_DEPTH + 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 34;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_lookup_row;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       in_valid      = 1'b0;
    t_in_item   in_data       = '0;
    logic       out_stall     = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [6:0] cfg_wr_data   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;

    // shadow of the block: breakpoint table and scan length
    logic signed [31:0] bp_x [TABLE_DEPTH];
    logic signed [31:0] bp_y [TABLE_DEPTH];
    logic [6:0]         points;

    t_out_item   awaited_values [$];
    t_lookup_row directed [$];
    int          items_issued = 0;
    int          errors       = 0;
    int          cycles       = 0;
    bit          idle_on      = 1'b1;

    piecewise_linear_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, awaited_values.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic int clip_points(input logic [6:0] n);
        return (n > TABLE_DEPTH) ? TABLE_DEPTH : int'(n);
    endfunction

    function automatic t_out_item interpolate(input logic signed [31:0] q);
        t_out_item  r;
        int         n;
        longint     x0, x1, y0, y1, dy;
        bit [63:0]  dq, dx, mag, quo;
        r = '0;
        n = clip_points(points);
        for (int k = 0; k + 1 < n; k++) begin
            x0 = bp_x[k];
            x1 = bp_x[k + 1];
            if (longint'(q) >= x0 && longint'(q) <= x1) begin
                y0 = bp_y[k];
                y1 = bp_y[k + 1];
                r.in_range = 1'b1;
                if (x1 == x0) begin
                    r.result_y = 32'(y0);
                end else begin
                    dx  = 64'(x1 - x0);
                    dq  = 64'(longint'(q) - x0);
                    dy  = y1 - y0;
                    mag = (dy < 0) ? 64'(-dy) : 64'(dy);
                    // product stays below 2^64, quotient never exceeds |dy|
                    quo = (dq * mag) / dx;
                    r.result_y = (dy < 0) ? 32'(y0 - longint'(quo)) : 32'(y0 + longint'(quo));
                end
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_in_item load_item(input int idx, input logic [31:0] x,
                                           input logic [31:0] y);
        t_in_item it;
        it.mode        = MODE_LOAD;
        it.entry_index = 6'(idx);
        it.point_x     = x;
        it.point_y     = y;
        it.query_x     = $urandom;
        return it;
    endfunction

    function automatic t_in_item query_item(input logic [31:0] q);
        t_in_item it;
        it.mode        = MODE_QUERY;
        it.entry_index = 6'($urandom);
        it.point_x     = $urandom;
        it.point_y     = $urandom;
        it.query_x     = q;
        return it;
    endfunction

    function automatic t_lookup_row row(input t_in_item it, input bit typed = 1'b0,
                                        input logic [31:0] y = '0, input bit hit = 1'b0);
        t_lookup_row r;
        r.item         = it;
        r.typed        = typed;
        r.res.result_y = y;
        r.res.in_range = hit;
        return r;
    endfunction

    function automatic logic [31:0] pick_y();
        int c;
        c = $urandom_range(0, 9);
        if (c == 0) return 32'h7FFF_FFFF;
        if (c == 1) return 32'h8000_0000;
        return $urandom;
    endfunction

    // mostly inside a segment or on a breakpoint, some anywhere
    function automatic logic [31:0] pick_query(input int n);
        int        c, k;
        longint    lo, hi;
        bit [63:0] off;
        c = $urandom_range(0, 9);
        if (n < 2 || c == 8) return $urandom;
        if (c == 6 || c == 7) return bp_x[$urandom_range(0, n - 1)];
        if (c == 9) return bp_x[$urandom_range(0, n - 1)] + (($urandom_range(0, 1) != 0) ? 1 : -1);
        k  = $urandom_range(0, n - 2);
        lo = bp_x[k];
        hi = bp_x[k + 1];
        if (hi < lo) return $urandom;
        off = {$urandom, $urandom} % 64'(hi - lo + 1);
        return 32'(lo + longint'(off));
    endfunction

    // entered just after a rising edge; returns at the edge that took the transaction
    task automatic send_item(input t_in_item it, input bit typed = 1'b0,
                             input t_out_item typed_res = '0);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_issued++;
        if (it.mode == MODE_LOAD) begin
            bp_x[it.entry_index] = it.point_x;
            bp_y[it.entry_index] = it.point_y;
        end else begin
            awaited_values.push_back(typed ? typed_res : interpolate(it.query_x));
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_values.size() != 0) @(posedge i_clk);
        // quiet tail, in which any unexpected result is still flagged
        repeat (QUIET_TAIL) @(posedge i_clk);
    endtask

    task automatic write_points(input logic [6:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        points = v;
    endtask

    task automatic load_layout(input int n);
        int xs [$];
        int style, acc;
        style = $urandom_range(0, 19);
        acc   = (style < 10) ? (int'($urandom) >>> 2)
                             : int'($urandom_range(0, 2000 << 16)) - (1000 << 16);
        for (int i = 0; i < n; i++) begin
            if (style <= 5 || style >= 17) begin
                xs.push_back(int'($urandom));
            end else if (style <= 9) begin
                xs.push_back(acc);
                acc += $urandom_range(0, 3);      // plenty of zero-width segments
            end else begin
                xs.push_back(acc);
                acc += int'($urandom_range(1, 50 << 16));
            end
        end
        if (style <= 5) xs.sort();
        for (int i = 0; i < n; i++) send_item(load_item(i, xs[i], pick_y()));
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (awaited_values.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual y=%h hit=%b",
                         $time, o_out_data.result_y, o_out_data.in_range);
                errors++;
            end else begin
                want = awaited_values.pop_front();
                if (o_out_data.result_y !== want.result_y) begin
                    $display("%0t: result_y mismatch: expected %h, actual %h",
                             $time, want.result_y, o_out_data.result_y);
                    errors++;
                end
                if (o_out_data.in_range !== want.in_range) begin
                    $display("%0t: in_range mismatch: expected %b, actual %b",
                             $time, want.in_range, o_out_data.in_range);
                    errors++;
                end
            end
        end
        out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end

    initial begin : stimulus
        int n, neff, phase;
        points = 7'd2;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-range segment, then zero-width, descending, ordinary and
        // negative-slope segments
        directed.push_back(row(load_item(0, 32'h8000_0000, 32'h7FFF_FFFF)));
        directed.push_back(row(load_item(1, 32'h7FFF_FFFF, 32'h8000_0000)));
        directed.push_back(row(query_item(32'h8000_0000), 1'b1, 32'h7FFF_FFFF, 1'b1));
        directed.push_back(row(query_item(32'h7FFF_FFFF), 1'b1, 32'h8000_0000, 1'b1));
        directed.push_back(row(query_item(32'h0000_0000)));
        directed.push_back(row(query_item(32'hFFFF_FFFF)));
        directed.push_back(row(load_item(0, 32'h0001_0000, 32'h1234_5678)));
        directed.push_back(row(load_item(1, 32'h0001_0000, 32'h7FFF_FFFF)));
        directed.push_back(row(query_item(32'h0001_0000), 1'b1, 32'h1234_5678, 1'b1));
        directed.push_back(row(query_item(32'h0001_0001), 1'b1, 32'h0, 1'b0));
        directed.push_back(row(query_item(32'h0000_FFFF), 1'b1, 32'h0, 1'b0));
        directed.push_back(row(load_item(1, 32'h0000_0000, 32'h0000_0001)));
        directed.push_back(row(query_item(32'h0000_8000), 1'b1, 32'h0, 1'b0));
        directed.push_back(row(query_item(32'h0000_0000), 1'b1, 32'h0, 1'b0));
        directed.push_back(row(load_item(0, 32'hFFFF_0000, 32'hFFFE_0000)));
        directed.push_back(row(load_item(1, 32'h0003_0000, 32'h0006_0000)));
        directed.push_back(row(query_item(32'h0001_0000)));
        directed.push_back(row(query_item(32'h0000_1234)));
        directed.push_back(row(query_item(32'h0003_0001), 1'b1, 32'h0, 1'b0));
        directed.push_back(row(query_item(32'hFFFE_FFFF), 1'b1, 32'h0, 1'b0));
        directed.push_back(row(load_item(1, 32'h0000_0003, 32'hFFFF_FFF9)));
        directed.push_back(row(load_item(0, 32'h0000_0000, 32'h0000_0000)));
        directed.push_back(row(query_item(32'h0000_0001)));
        directed.push_back(row(query_item(32'h0000_0002)));
        directed.push_back(row(query_item(32'h0000_0003), 1'b1, 32'hFFFF_FFF9, 1'b1));
        foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].res);

        // scan lengths: none, below minimum, full table, beyond table, minimum, then random
        phase = 0;
        while (items_issued < ITEM_TARGET) begin
            case (phase)
                0:       n = 0;
                1:       n = 1;
                2:       n = 64;
                3:       n = 127;
                4:       n = 2;
                default: n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 63)
                                                         : $urandom_range(3, 12);
            endcase
            settle();
            idle_on = (phase != 2);
            write_points(7'(n));
            neff = clip_points(7'(n));
            load_layout((neff < 2) ? 2 : neff);
            repeat ($urandom_range(20, 40)) begin
                if ($urandom_range(0, 99) < 12)
                    send_item(load_item($urandom_range(0, 63), $urandom, pick_y()));
                else
                    send_item(query_item(pick_query(neff)));
            end
            phase++;
        end
        settle();

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
